// File: hw/rtl/aes_pkg.sv
`timescale 1ns / 1ps
// aes_pkg: word types, update/status structs, state codes and constants
// for the absolute error statistics block. No dependencies.
package aes_pkg;

   localparam int VALUE_W = 16;
   localparam int COUNT_W = 32;
   localparam int ABS_SUM_W = 48;
   localparam int REL_SUM_W = 64;
   localparam int REL_W = 32;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [VALUE_W-1:0] correct_value;
      logic [VALUE_W-1:0] observed_value;
   } aes_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   sample_count;
      logic [ABS_SUM_W-1:0] abs_error_sum;
      logic [REL_SUM_W-1:0] rel_error_sum;
      logic [VALUE_W-1:0]   abs_error_max;
      logic [VALUE_W-1:0]   abs_error_min;
      logic [REL_W-1:0]     rel_error_max;
      logic [REL_W-1:0]     rel_error_min;
      logic                 zero_reference;
   } aes_rsp_type;

   // one statistics update, from the sequencer to the accumulators
   typedef struct packed {
      logic               valid;
      logic               clear;
      logic [VALUE_W-1:0] abs_err;
      logic [REL_W-1:0]   rel_err;
   } aes_upd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } aes_div_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPDATE,
      ST_WRITE
   } aes_state_type;

endpackage

// File: hw/rtl/aes_divider.sv
`timescale 1ns / 1ps
// aes_divider: restoring divider, one quotient bit per cycle, giving
// (abs_err << FRAC_BITS) / divisor saturated to 32 bits. Uses aes_pkg.
module aes_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [aes_pkg::VALUE_W-1:0] dividend,
   input  logic [aes_pkg::VALUE_W-1:0] divisor,
   output aes_pkg::aes_div_status_type status,
   output logic [aes_pkg::REL_W-1:0]   quotient
);
   import aes_pkg::*;

   localparam int DW = VALUE_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]      d_ff, d_in;
   logic [VALUE_W-1:0] r_ff, r_in;
   logic [VALUE_W-1:0] dv_ff, dv_in;
   logic [REL_W-1:0]   q_ff, q_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [VALUE_W:0] trial;
   logic [VALUE_W:0] diff;
   logic             ge;

   assign trial = {r_ff, d_ff[DW-1]};
   assign diff = trial - {1'b0, dv_ff};
   assign ge = (trial >= {1'b0, dv_ff});

   always_comb begin
      d_in = d_ff;
      r_in = r_ff;
      dv_in = dv_ff;
      q_in = q_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         d_in = {dividend, {FRAC_BITS{1'b0}}};
         r_in = '0;
         dv_in = divisor;
         q_in = '0;
         ovf_in = 1'b0;
         cnt_in = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         d_in = {d_ff[DW-2:0], 1'b0};
         r_in = ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
         // quotient bits past the 32-bit field only mark saturation
         q_in = {q_ff[REL_W-2:0], ge};
         ovf_in = ovf_ff | q_ff[REL_W-1];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      d_ff <= d_in;
      r_ff <= r_in;
      dv_ff <= dv_in;
      q_ff <= q_in;
      ovf_ff <= ovf_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = ovf_ff ? '1 : q_ff;

endmodule

// File: hw/rtl/aes_accum.sv
`timescale 1ns / 1ps
// aes_accum: sample count, error sums and min/max registers with
// saturation and clear. Uses aes_pkg.
module aes_accum #(
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aes_pkg::aes_upd_type          upd,
   output logic [aes_pkg::COUNT_W-1:0]   sample_count,
   output logic [aes_pkg::ABS_SUM_W-1:0] abs_error_sum,
   output logic [aes_pkg::REL_SUM_W-1:0] rel_error_sum,
   output logic [aes_pkg::VALUE_W-1:0]   abs_error_max,
   output logic [aes_pkg::VALUE_W-1:0]   abs_error_min,
   output logic [aes_pkg::REL_W-1:0]     rel_error_max,
   output logic [aes_pkg::REL_W-1:0]     rel_error_min
);
   import aes_pkg::*;

   // count limit is capped at the 32-bit field
   localparam int CW = (COUNT_BITS > COUNT_W) ? COUNT_W : COUNT_BITS;

   logic [CW-1:0]        count_ff, count_in;
   logic [ABS_SUM_W-1:0] abs_sum_ff, abs_sum_in;
   logic [REL_SUM_W-1:0] rel_sum_ff, rel_sum_in;
   logic [VALUE_W-1:0]   abs_max_ff, abs_max_in;
   logic [VALUE_W-1:0]   abs_min_ff, abs_min_in;
   logic [REL_W-1:0]     rel_max_ff, rel_max_in;
   logic [REL_W-1:0]     rel_min_ff, rel_min_in;

   logic [ABS_SUM_W:0] abs_add;
   logic [REL_SUM_W:0] rel_add;

   assign abs_add = {1'b0, abs_sum_ff} + (ABS_SUM_W + 1)'(upd.abs_err);
   assign rel_add = {1'b0, rel_sum_ff} + (REL_SUM_W + 1)'(upd.rel_err);

   always_comb begin
      count_in = count_ff;
      abs_sum_in = abs_sum_ff;
      rel_sum_in = rel_sum_ff;
      abs_max_in = abs_max_ff;
      abs_min_in = abs_min_ff;
      rel_max_in = rel_max_ff;
      rel_min_in = rel_min_ff;
      if (upd.valid) begin
         if (upd.clear) begin
            count_in = '0;
            abs_sum_in = '0;
            rel_sum_in = '0;
            abs_max_in = '0;
            abs_min_in = '1;
            rel_max_in = '0;
            rel_min_in = '1;
         end else begin
            count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
            abs_sum_in = abs_add[ABS_SUM_W] ? '1 : abs_add[ABS_SUM_W-1:0];
            rel_sum_in = rel_add[REL_SUM_W] ? '1 : rel_add[REL_SUM_W-1:0];
            if (upd.abs_err > abs_max_ff) abs_max_in = upd.abs_err;
            if (upd.abs_err < abs_min_ff) abs_min_in = upd.abs_err;
            if (upd.rel_err > rel_max_ff) rel_max_in = upd.rel_err;
            if (upd.rel_err < rel_min_ff) rel_min_in = upd.rel_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         abs_sum_ff <= '0;
         rel_sum_ff <= '0;
         abs_max_ff <= '0;
         abs_min_ff <= '1;
         rel_max_ff <= '0;
         rel_min_ff <= '1;
      end else begin
         count_ff <= count_in;
         abs_sum_ff <= abs_sum_in;
         rel_sum_ff <= rel_sum_in;
         abs_max_ff <= abs_max_in;
         abs_min_ff <= abs_min_in;
         rel_max_ff <= rel_max_in;
         rel_min_ff <= rel_min_in;
      end
   end

   assign sample_count = COUNT_W'(count_ff);
   assign abs_error_sum = abs_sum_ff;
   assign rel_error_sum = rel_sum_ff;
   assign abs_error_max = abs_max_ff;
   assign abs_error_min = abs_min_ff;
   assign rel_error_max = rel_max_ff;
   assign rel_error_min = rel_min_ff;

endmodule

// File: hw/rtl/abs_error_statistics.sv
`timescale 1ns / 1ps
// abs_error_statistics: running absolute/relative error statistics.
// A sample goes from accept through ST_DIV (the one-bit-per-cycle restoring divider),
// ST_UPDATE and ST_WRITE to rsp_valid; a clear skips ST_DIV. ST_WRITE holds for a waiting result.
// One word at a time: the next is taken once the state is back in ST_IDLE, as rsp_valid rises;
// it may be taken while the last result waits.
// Reset (synchronous): all statistics return to their cleared values, no result pending.
module abs_error_statistics #(
   parameter int VALUE_FRAC_BITS = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  aes_pkg::aes_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output aes_pkg::aes_rsp_type rsp_data
);
   import aes_pkg::*;

   aes_state_type state_ff, state_in;
   logic          zero_ff, zero_in;
   logic          clear_ff, clear_in;
   logic [VALUE_W-1:0] aerr_ff, aerr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   aes_rsp_type   rsp_ff, rsp_in;

   logic               accept;
   logic               div_start;
   logic [VALUE_W-1:0] aerr;
   aes_div_status_type div_status;
   logic [REL_W-1:0]   div_q;
   aes_upd_type        upd;
   aes_rsp_type        stats;

   assign accept = req_valid && req_ready;
   assign aerr = (req_data.correct_value >= req_data.observed_value)
      ? req_data.correct_value - req_data.observed_value
      : req_data.observed_value - req_data.correct_value;

   aes_divider #(
      .FRAC_BITS(VALUE_FRAC_BITS)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(aerr),
      .divisor(req_data.correct_value),
      .status(div_status),
      .quotient(div_q)
   );

   assign upd.valid = (state_ff == ST_UPDATE);
   assign upd.clear = clear_ff;
   assign upd.abs_err = aerr_ff;
   // zero reference saturates the relative error
   assign upd.rel_err = zero_ff ? '1 : div_q;

   aes_accum #(
      .COUNT_BITS(COUNT_BITS)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .upd(upd),
      .sample_count(stats.sample_count),
      .abs_error_sum(stats.abs_error_sum),
      .rel_error_sum(stats.rel_error_sum),
      .abs_error_max(stats.abs_error_max),
      .abs_error_min(stats.abs_error_min),
      .rel_error_max(stats.rel_error_max),
      .rel_error_min(stats.rel_error_min)
   );
   assign stats.zero_reference = zero_ff;

   always_comb begin
      state_in = state_ff;
      zero_in = zero_ff;
      clear_in = clear_ff;
      aerr_in = aerr_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               aerr_in = aerr;
               if (req_data.req_type == REQ_CLEAR) begin
                  clear_in = 1'b1;
                  zero_in = 1'b0;
                  state_in = ST_UPDATE;
               end else begin
                  clear_in = 1'b0;
                  zero_in = (req_data.correct_value == '0);
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // hold until the previous result word has left
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = stats;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zero_ff <= zero_in;
      clear_ff <= clear_in;
      aerr_ff <= aerr_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for abs_error_statistics, with its own running statistics
// predictor, a bursty word sender and a stalling result receiver. Depends on aes_pkg.
module testbench;
   import aes_pkg::*;

   localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int TAIL_CYCLES = 80;    // drain time after the last expected result
   localparam int REQ_W = $bits(aes_req_type);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   aes_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   aes_rsp_type rsp_data;

   // predicted statistics
   logic [COUNT_W-1:0]   stat_count;
   logic [ABS_SUM_W-1:0] stat_abs_sum;
   logic [REL_SUM_W-1:0] stat_rel_sum;
   logic [VALUE_W-1:0]   stat_abs_max;
   logic [VALUE_W-1:0]   stat_abs_min;
   logic [REL_W-1:0]     stat_rel_max;
   logic [REL_W-1:0]     stat_rel_min;

   aes_rsp_type pending_stats[$];
   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   logic [31:0] ready_cycle = '0;

   abs_error_statistics u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_stats();
      stat_count   = '0;
      stat_abs_sum = '0;
      stat_rel_sum = '0;
      stat_abs_max = '0;
      stat_abs_min = '1;
      stat_rel_max = '0;
      stat_rel_min = '1;
   endfunction

   // applies one word to the predicted statistics and returns the expected result
   function automatic aes_rsp_type predict_stats(input aes_req_type w);
      aes_rsp_type          r;
      logic [VALUE_W-1:0]   aerr;
      logic [47:0]          quot;
      logic [REL_W-1:0]     rerr;
      logic [ABS_SUM_W:0]   abs_next;
      logic [REL_SUM_W:0]   rel_next;
      r = '0;
      if (w.req_type == REQ_CLEAR) begin
         clear_stats();
      end else begin
         aerr = (w.correct_value >= w.observed_value) ?
                w.correct_value - w.observed_value : w.observed_value - w.correct_value;
         if (w.correct_value == '0) begin
            rerr = '1;
            r.zero_reference = 1'b1;
         end else begin
            quot = {16'b0, aerr, 16'b0} / {32'b0, w.correct_value};
            rerr = (quot > 48'h0000_FFFF_FFFF) ? '1 : quot[REL_W-1:0];
         end
         if (stat_count != '1) stat_count = stat_count + 1'b1;
         abs_next = {1'b0, stat_abs_sum} + (ABS_SUM_W + 1)'(aerr);
         stat_abs_sum = abs_next[ABS_SUM_W] ? '1 : abs_next[ABS_SUM_W-1:0];
         rel_next = {1'b0, stat_rel_sum} + (REL_SUM_W + 1)'(rerr);
         stat_rel_sum = rel_next[REL_SUM_W] ? '1 : rel_next[REL_SUM_W-1:0];
         if (aerr > stat_abs_max) stat_abs_max = aerr;
         if (aerr < stat_abs_min) stat_abs_min = aerr;
         if (rerr > stat_rel_max) stat_rel_max = rerr;
         if (rerr < stat_rel_min) stat_rel_min = rerr;
      end
      r.sample_count  = stat_count;
      r.abs_error_sum = stat_abs_sum;
      r.rel_error_sum = stat_rel_sum;
      r.abs_error_max = stat_abs_max;
      r.abs_error_min = stat_abs_min;
      r.rel_error_max = stat_rel_max;
      r.rel_error_min = stat_rel_min;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // result check first, then prediction of the word accepted at this edge
   always @(posedge clock) begin
      aes_rsp_type exp_s;
      if (reset) begin
         clear_stats();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_stats.size() == 0) begin
               $display("%0t: unexpected result word, expected none actual %0h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               exp_s = pending_stats.pop_front();
               compare_field("sample_count", 64'(exp_s.sample_count),
                             64'(rsp_data.sample_count));
               compare_field("abs_error_sum", 64'(exp_s.abs_error_sum),
                             64'(rsp_data.abs_error_sum));
               compare_field("rel_error_sum", exp_s.rel_error_sum, rsp_data.rel_error_sum);
               compare_field("abs_error_max", 64'(exp_s.abs_error_max),
                             64'(rsp_data.abs_error_max));
               compare_field("abs_error_min", 64'(exp_s.abs_error_min),
                             64'(rsp_data.abs_error_min));
               compare_field("rel_error_max", 64'(exp_s.rel_error_max),
                             64'(rsp_data.rel_error_max));
               compare_field("rel_error_min", 64'(exp_s.rel_error_min),
                             64'(rsp_data.rel_error_min));
               compare_field("zero_reference", 64'(exp_s.zero_reference),
                             64'(rsp_data.zero_reference));
            end
         end
         if (req_valid && req_ready) pending_stats.push_back(predict_stats(req_data));
      end
   end

   // receiver: always ready, light stalls, heavy stalls, then a fixed stall mask
   always @(posedge clock) begin
      logic [15:0] stall_mask;
      stall_mask = 16'b1011_0111_0110_1101;
      ready_cycle <= ready_cycle + 1'b1;
      case (ready_cycle[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= stall_mask[ready_cycle[3:0]];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("abs_error_statistics test failed");
      $finish;
   end

   // sends one word; valid stays high between words of a burst
   task automatic send_word(input logic kind, input logic [VALUE_W-1:0] cv,
                            input logic [VALUE_W-1:0] ov);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 9) < 4) gap = 0;
         else if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 5);
         else gap = $urandom_range(6, 60);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_data <= REQ_W'({$urandom, $urandom});
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data.req_type <= kind;
      req_data.correct_value <= cv;
      req_data.observed_value <= ov;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_reset_values();
      send_word(REQ_CLEAR, 16'h0000, 16'h0000);
      send_word(REQ_SAMPLE, 16'h0000, 16'h0000);  // zero reference, zero error
   endtask

   task automatic run_corner_samples();
      send_word(REQ_SAMPLE, 16'hFFFF, 16'h0000);
      send_word(REQ_SAMPLE, 16'h0000, 16'hFFFF);
      send_word(REQ_SAMPLE, 16'hFFFF, 16'hFFFF);
      send_word(REQ_SAMPLE, 16'h0001, 16'hFFFF);  // largest quotient
      send_word(REQ_SAMPLE, 16'h0001, 16'h0000);
      send_word(REQ_SAMPLE, 16'h0001, 16'h0001);
      send_word(REQ_SAMPLE, 16'hFFFF, 16'hFFFE);
      send_word(REQ_SAMPLE, 16'h8000, 16'h7FFF);
      send_word(REQ_SAMPLE, 16'h5555, 16'hAAAA);
      send_word(REQ_SAMPLE, 16'hAAAA, 16'h5555);
      send_word(REQ_SAMPLE, 16'h0002, 16'h0001);
      send_word(REQ_SAMPLE, 16'h0003, 16'h0001);  // truncated quotient
   endtask

   task automatic run_clear_requests();
      send_word(REQ_CLEAR, 16'hFFFF, 16'h0000);   // value fields ignored
      send_word(REQ_SAMPLE, 16'h0100, 16'h0180);
      send_word(REQ_CLEAR, 16'h1234, 16'hFFFF);
      send_word(REQ_CLEAR, 16'h0000, 16'h0000);
      send_word(REQ_SAMPLE, 16'h0000, 16'hFFFF);  // zero reference with max error
      send_word(REQ_SAMPLE, 16'h7FFF, 16'h8000);
   endtask

   task automatic run_random_traffic(input int n_words);
      logic [VALUE_W-1:0] corner_vals[6];
      logic [VALUE_W-1:0] cv;
      logic [VALUE_W-1:0] ov;
      int                 pick;
      corner_vals = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
      for (int i = 0; i < n_words; i++) begin
         pick = $urandom_range(0, 99);
         cv = VALUE_W'($urandom);
         ov = VALUE_W'($urandom);
         if (pick < 4) begin
            send_word(REQ_CLEAR, cv, ov);
         end else begin
            if (pick < 10) cv = '0;
            else if (pick < 25) ov = cv + 16'($signed($urandom_range(0, 16)) - 8);
            else if (pick < 35) cv = VALUE_W'($urandom_range(1, 255));
            else if (pick < 45) begin
               cv = corner_vals[$urandom_range(0, 5)];
               ov = corner_vals[$urandom_range(0, 5)];
            end
            send_word(REQ_SAMPLE, cv, ov);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_reset_values();
      run_corner_samples();
      run_clear_requests();
      run_random_traffic(630);
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_stats.size() != 0) begin
         $display("%0t: result words missing, expected %0d actual 0",
                  $time, pending_stats.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("abs_error_statistics test passed");
      else
         $display("abs_error_statistics test failed");
      $finish;
   end

endmodule
